### hw/rtl/sorted_integer_set_top_defines.svh
// ----------------------------------------------------------------------------
// Sorted integer set: assertion macros
// Shared property wrappers, sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_INTEGER_SET_TOP_DEFINES_SVH
`define SORTED_INTEGER_SET_TOP_DEFINES_SVH

// Same-cycle implication
`define SIS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted set check failed");

// Next-cycle implication
`define SIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted set check failed");

`endif

### hw/rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// Sorted integer set package
// Request codes, sequencer states, field widths and shared structs.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int DATA_W      = 32;
  localparam int RANK_W      = 6;
  localparam int COUNT_OUT_W = 7;
  // Cells folded into one first-level match register
  localparam int GROUP_SIZE  = 32;
  // Ranks reachable through the rank field
  localparam int RANK_LIMIT  = 64;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_QUERY,
    KIND_CLEAR,
    KIND_READ
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROUP,
    ST_MERGE,
    ST_COMMIT
  } state_e;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic                     cmp_en;
    logic                     ins_en;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic                     member;
    logic                     inserted;
    logic                     refused_full;
    logic [COUNT_OUT_W-1:0]   element_count;
    logic signed [DATA_W-1:0] element_at_rank;
    logic                     rank_valid;
  } result_t;

endpackage

### hw/rtl/sis_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one set operation.
// ----------------------------------------------------------------------------
interface sis_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [31:0] value;
  logic [5:0]  rank;

  modport source (output valid, output kind, output value, output rank, input ready);
  modport sink   (input valid, input kind, input value, input rank, output ready);
endinterface

### hw/rtl/sis_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the outcome of one set operation.
// ----------------------------------------------------------------------------
interface sis_rsp_if;
  logic        valid;
  logic        ready;
  logic        member;
  logic        inserted;
  logic        refused_full;
  logic [6:0]  element_count;
  logic signed [31:0] element_at_rank;
  logic        rank_valid;

  modport source (output valid, output member, output inserted, output refused_full,
                  output element_count, output element_at_rank, output rank_valid,
                  input ready);
  modport sink   (input valid, input member, input inserted, input refused_full,
                  input element_count, input element_at_rank, input rank_valid,
                  output ready);
endinterface

### hw/rtl/sis_cell.sv
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one element, compares it with the broadcast value and, on insert,
// keeps it, takes the new value or takes its lower neighbor's element.
// ----------------------------------------------------------------------------
module sis_cell (
  input  logic                              clk_i,
  input  sis_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              occ_i,
  input  logic                              prev_lt_i,
  input  logic signed [sis_pkg::DATA_W-1:0] prev_elem_i,
  output logic signed [sis_pkg::DATA_W-1:0] elem_o,
  output logic                              lt_o,
  output logic                              eq_o
);
  import sis_pkg::*;

  logic signed [DATA_W-1:0] elem_q, elem_d;
  logic                     lt_q, lt_d;

  // Compare against the broadcast value
  assign lt_d = occ_i && (elem_q < ctrl_i.value);
  assign eq_o = occ_i && (elem_q == ctrl_i.value);

  // Keep below the insert point, drop the value in at it, shift up above it
  always_comb begin
    elem_d = elem_q;
    if (ctrl_i.ins_en && !lt_q) begin
      if (prev_lt_i) begin
        elem_d = ctrl_i.value;
      end else begin
        elem_d = prev_elem_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    if (ctrl_i.cmp_en) begin
      lt_q <= lt_d;
    end
  end

  assign elem_o = elem_q;
  assign lt_o   = lt_q;

endmodule

### hw/rtl/sis_group.sv
// ----------------------------------------------------------------------------
// Sorted set match group
// First reduction level: folds the match flags and the rank-selected element
// of one group of cells into registers.
// ----------------------------------------------------------------------------
module sis_group (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [sis_pkg::GROUP_SIZE-1:0]    hit_i,
  input  logic [sis_pkg::GROUP_SIZE-1:0]    sel_i,
  input  logic [sis_pkg::DATA_W-1:0]        data_i [sis_pkg::GROUP_SIZE],
  output logic                              hit_o,
  output logic [sis_pkg::DATA_W-1:0]        data_o
);
  import sis_pkg::*;

  logic              hit_q, hit_d;
  logic [DATA_W-1:0] data_q, data_d;

  // Fold the group; at most one cell is selected
  always_comb begin
    hit_d  = |hit_i;
    data_d = '0;
    for (int k = 0; k < GROUP_SIZE; k++) begin
      data_d = data_d | (sel_i[k] ? data_i[k] : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= hit_d;
      data_q <= data_d;
    end
  end

  assign hit_o  = hit_q;
  assign data_o = data_q;

endmodule

### hw/rtl/sorted_integer_set_top.sv
// ----------------------------------------------------------------------------
// Sorted integer set
// Ordered set of distinct signed 32-bit integers kept in a row of cells.
// ----------------------------------------------------------------------------
// One request is worked on at a time and passes through four steps (accept,
// compare and group fold, group merge, commit). The response register is
// loaded in the commit step, so a new request is taken only after the
// previous one has committed. The two-level registered match reduction
// across the cell row gives the fold and merge steps. A commit waits while an
// earlier response is still unread. A new request is taken while the previous
// response still waits to be read. Insert, query, clear and read-at-rank all
// return one response. Membership always refers to the set before the
// request. Reset empties the set at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sorted_integer_set_top_defines.svh"

module sorted_integer_set_top #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sis_req_if.sink     req_i,
  sis_rsp_if.source   rsp_o
);
  import sis_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NPAD   = NGROUP * GROUP_SIZE;
  localparam int CMP_W  = CNT_W + RANK_W;

  state_e state_q, state_d;

  // Request registers
  kind_e                    kind_q;
  logic signed [DATA_W-1:0] value_q;
  logic [RANK_W-1:0]        rank_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic             full;

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic accept, grp_en, merge_en, commit, ins_en;

  logic        member_q, member_d;
  logic [DATA_W-1:0] rd_q, rd_d;

  cell_ctrl_t ctrl;

  logic signed [DATA_W-1:0] elem [CAPACITY];
  logic [CAPACITY-1:0]      lt, eq, occ, sel;

  logic [NPAD-1:0]   hit_pad, sel_pad;
  logic [DATA_W-1:0] data_pad [NPAD];
  logic [NGROUP-1:0] grp_hit;
  logic [DATA_W-1:0] grp_data [NGROUP];

  logic [CMP_W-1:0]       rank_ext, count_ext;
  logic [CNT_W+COUNT_OUT_W-1:0] count_out_ext;
  logic                   rank_ok;

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (req_i.valid) state_d = ST_GROUP;
      ST_GROUP:  state_d = ST_MERGE;
      ST_MERGE:  state_d = ST_COMMIT;
      ST_COMMIT: if (!out_valid_q || rsp_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req_i.ready = 1'b0;
    grp_en      = 1'b0;
    merge_en    = 1'b0;
    commit      = 1'b0;
    case (state_q)
      ST_IDLE:   req_i.ready = 1'b1;
      ST_GROUP:  grp_en = 1'b1;
      ST_MERGE:  merge_en = 1'b1;
      ST_COMMIT: commit = !out_valid_q || rsp_o.ready;
      default:   req_i.ready = 1'b0;
    endcase
  end

  assign accept = req_i.valid && req_i.ready;
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign ins_en = commit && (kind_q == KIND_INSERT) && !member_q && !full;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_e'(req_i.kind);
      value_q <= req_i.value;
      rank_q  <= req_i.rank;
    end
  end

  // Broadcast to the row
  assign ctrl.cmp_en = grp_en;
  assign ctrl.ins_en = ins_en;
  assign ctrl.value  = value_q;

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (count_q > CNT_W'(i));
    if (i < RANK_LIMIT) begin : g_rank
      assign sel[i] = occ[i] && (rank_q == RANK_W'(i));
    end else begin : g_norank
      assign sel[i] = 1'b0;
    end
    if (i == 0) begin : g_first
      sis_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .occ_i       (occ[i]),
        .prev_lt_i   (1'b1),
        .prev_elem_i (value_q),
        .elem_o      (elem[i]),
        .lt_o        (lt[i]),
        .eq_o        (eq[i])
      );
    end else begin : g_next
      sis_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .occ_i       (occ[i]),
        .prev_lt_i   (lt[i-1]),
        .prev_elem_i (elem[i-1]),
        .elem_o      (elem[i]),
        .lt_o        (lt[i]),
        .eq_o        (eq[i])
      );
    end
  end

  // Pad the row out to whole groups
  for (genvar i = 0; i < NPAD; i++) begin : g_pad
    if (i < CAPACITY) begin : g_real
      assign hit_pad[i]  = eq[i];
      assign sel_pad[i]  = sel[i];
      assign data_pad[i] = elem[i];
    end else begin : g_fill
      assign hit_pad[i]  = 1'b0;
      assign sel_pad[i]  = 1'b0;
      assign data_pad[i] = '0;
    end
  end

  // First reduction level
  for (genvar g = 0; g < NGROUP; g++) begin : g_group
    logic [DATA_W-1:0] gdata [GROUP_SIZE];
    for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_tap
      assign gdata[k] = data_pad[g*GROUP_SIZE + k];
    end
    sis_group u_group (
      .clk_i  (clk_i),
      .en_i   (grp_en),
      .hit_i  (hit_pad[g*GROUP_SIZE +: GROUP_SIZE]),
      .sel_i  (sel_pad[g*GROUP_SIZE +: GROUP_SIZE]),
      .data_i (gdata),
      .hit_o  (grp_hit[g]),
      .data_o (grp_data[g])
    );
  end

  // Second reduction level
  always_comb begin
    member_d = |grp_hit;
    rd_d     = '0;
    for (int g = 0; g < NGROUP; g++) begin
      rd_d = rd_d | grp_data[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge_en) begin
      member_q <= member_d;
      rd_q     <= rd_d;
    end
  end

  // Occupancy update
  always_comb begin
    count_d = count_q;
    if (commit) begin
      if (kind_q == KIND_CLEAR) begin
        count_d = '0;
      end else if (ins_en) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  // Build the response
  assign rank_ext      = {{CNT_W{1'b0}}, rank_q};
  assign count_ext     = {{RANK_W{1'b0}}, count_q};
  assign rank_ok       = (kind_q == KIND_READ) && (rank_ext < count_ext);
  assign count_out_ext = {{COUNT_OUT_W{1'b0}}, count_d};

  always_comb begin
    res_d.member          = member_q;
    res_d.inserted        = ins_en;
    res_d.refused_full    = (kind_q == KIND_INSERT) && !member_q && full;
    res_d.element_count   = count_out_ext[COUNT_OUT_W-1:0];
    res_d.element_at_rank = rank_ok ? rd_q : '0;
    res_d.rank_valid      = rank_ok;
  end

  // Hold the response until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.member          = res_q.member;
  assign rsp_o.inserted        = res_q.inserted;
  assign rsp_o.refused_full    = res_q.refused_full;
  assign rsp_o.element_count   = res_q.element_count;
  assign rsp_o.element_at_rank = res_q.element_at_rank;
  assign rsp_o.rank_valid      = res_q.rank_valid;

  // Checks
  `SIS_ASSERT_IMPLIES(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
  `SIS_ASSERT_IMPLIES(a_member_excl, rsp_o.valid, !(rsp_o.member && rsp_o.inserted))
  `SIS_ASSERT_IMPLIES(a_refuse_full, rsp_o.valid && rsp_o.refused_full, full)
  `SIS_ASSERT_NEXT(a_insert_grow, ins_en, count_q == $past(count_q) + CNT_W'(1))

endmodule

### tb/tb_sorted_integer_set_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted integer set testbench
// Drives insert, query, clear and read-at-rank requests through the request
// channel and checks every response against an ordered-set predictor or a
// typed table row. A directed table is followed by random episodes, each
// drawing most values from its own pool, so that duplicates, a full set and
// refused inserts occur, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_sorted_integer_set_top;
  import sis_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER_RSP = 150;
  localparam int IDLE_LIMIT     = 4000;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    kind_e                    kind;
    logic signed [DATA_W-1:0] value;
    logic [RANK_W-1:0]        rank;
    bit                       typed;
    result_t                  outcome;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  sis_req_if req_if ();
  sis_rsp_if rsp_if ();

  sorted_integer_set_top #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Predictor state: the set in ascending order and its size
  logic signed [DATA_W-1:0] set_elems [CAPACITY];
  int                       set_count;

  result_t     outcome_q [$];
  dir_row_t    dir_rows [$];
  result_t     outcome_want;
  result_t     outcome_next;
  int unsigned req_taken;
  int unsigned rsp_seen;
  int unsigned err_count;

  // Sender burst control
  int unsigned burst_left;
  bit          no_gap;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Apply one request to the predicted set and return its response
  function automatic result_t apply_request(input kind_e k, input logic signed [DATA_W-1:0] v,
                                            input logic [RANK_W-1:0] r);
    result_t res;
    int      pos;
    int      j;
    pos = 0;
    while (pos < set_count && set_elems[pos] < v) pos++;
    res = '0;
    res.member = (pos < set_count) && (set_elems[pos] == v);
    case (k)
      KIND_INSERT: begin
        if (!res.member) begin
          if (set_count >= CAPACITY) begin
            res.refused_full = 1'b1;
          end else begin
            for (j = set_count; j > pos; j--) set_elems[j] = set_elems[j-1];
            set_elems[pos] = v;
            set_count++;
            res.inserted = 1'b1;
          end
        end
      end
      KIND_CLEAR: begin
        set_count = 0;
      end
      KIND_READ: begin
        if (int'(r) < set_count) begin
          res.rank_valid      = 1'b1;
          res.element_at_rank = set_elems[r];
        end
      end
      default: ;
    endcase
    res.element_count = set_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic void add_dir(input kind_e k, input logic signed [DATA_W-1:0] v,
                                  input int r, input bit typed, input bit m, input bit ins,
                                  input bit refused, input int cnt,
                                  input logic signed [DATA_W-1:0] el, input bit rv);
    dir_row_t row;
    row.kind                    = k;
    row.value                   = v;
    row.rank                    = r[RANK_W-1:0];
    row.typed                   = typed;
    row.outcome                 = '0;
    row.outcome.member          = m;
    row.outcome.inserted        = ins;
    row.outcome.refused_full    = refused;
    row.outcome.element_count   = cnt[COUNT_OUT_W-1:0];
    row.outcome.element_at_rank = el;
    row.outcome.rank_valid      = rv;
    dir_rows = {dir_rows, row};
  endfunction

  task automatic report_mismatch(input string what, input int unsigned idx,
                                 input logic [DATA_W-1:0] got_v,
                                 input logic [DATA_W-1:0] want_v);
    $display("%0t: response %0d %s: got %0h want %0h", $time, idx, what, got_v, want_v);
    err_count++;
  endtask

  // Offer one request at a falling edge and hold it until accepted
  task automatic put_item(input kind_e k, input logic signed [DATA_W-1:0] v,
                          input logic [RANK_W-1:0] r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_gap ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= k;
    req_if.value <= v;
    req_if.rank  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Predict on accepted requests, check accepted responses
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("without request", rsp_seen, 0, 0);
        end else begin
          outcome_want = outcome_q.pop_front();
          if (rsp_if.member !== outcome_want.member)
            report_mismatch("member", rsp_seen, rsp_if.member, outcome_want.member);
          if (rsp_if.inserted !== outcome_want.inserted)
            report_mismatch("inserted", rsp_seen, rsp_if.inserted, outcome_want.inserted);
          if (rsp_if.refused_full !== outcome_want.refused_full)
            report_mismatch("refused_full", rsp_seen, rsp_if.refused_full,
                            outcome_want.refused_full);
          if (rsp_if.element_count !== outcome_want.element_count)
            report_mismatch("element_count", rsp_seen, rsp_if.element_count,
                            outcome_want.element_count);
          if (rsp_if.element_at_rank !== outcome_want.element_at_rank)
            report_mismatch("element_at_rank", rsp_seen, rsp_if.element_at_rank,
                            outcome_want.element_at_rank);
          if (rsp_if.rank_valid !== outcome_want.rank_valid)
            report_mismatch("rank_valid", rsp_seen, rsp_if.rank_valid,
                            outcome_want.rank_valid);
        end
        rsp_seen++;
      end
      if (req_if.valid && req_if.ready) begin
        outcome_next = apply_request(kind_e'(req_if.kind), req_if.value, req_if.rank);
        // Typed rows of the directed table replace the prediction
        if (req_taken < dir_rows.size() && dir_rows[req_taken].typed)
          outcome_next = dir_rows[req_taken].outcome;
        outcome_q = {outcome_q, outcome_next};
        req_taken++;
      end
    end
  end

  // Receiver: stall on shifting patterns, with one long hold-off
  initial begin
    int unsigned cyc;
    int unsigned mode;
    bit          hold_done;
    cyc       = 0;
    mode      = 0;
    hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (!hold_done && rsp_seen >= HOLD_AFTER_RSP) begin
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= $urandom_range(0, 1);
          2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= cyc[3];
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long
  initial begin
    int unsigned idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else idle++;
    end
    $display("tb_sorted_integer_set_top: errors");
    $finish;
  end

  // Stimulus
  initial begin
    logic signed [DATA_W-1:0] pool [$];
    logic signed [DATA_W-1:0] v;
    int unsigned              sent;
    int unsigned              episode;
    int unsigned              ep_len;
    int unsigned              pool_size;
    int unsigned              pick;
    int unsigned              i;
    int                       rank_top;
    kind_e                    k;
    logic [RANK_W-1:0]        r;

    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.kind  = KIND_INSERT;
    req_if.value = '0;
    req_if.rank  = '0;
    set_count    = 0;
    req_taken    = 0;
    rsp_seen     = 0;
    err_count    = 0;
    burst_left   = 0;
    no_gap       = 1'b0;

    // Directed table: empty set, extremes, duplicates, rank limits, clears
    add_dir(KIND_QUERY,  0,       0,  1, 0, 0, 0, 0, 0,       0);
    add_dir(KIND_READ,   0,       0,  1, 0, 0, 0, 0, 0,       0);
    add_dir(KIND_INSERT, VAL_MAX, 0,  1, 0, 1, 0, 1, 0,       0);
    add_dir(KIND_INSERT, VAL_MIN, 0,  1, 0, 1, 0, 2, 0,       0);
    add_dir(KIND_INSERT, VAL_MAX, 0,  1, 1, 0, 0, 2, 0,       0);
    add_dir(KIND_READ,   0,       0,  1, 0, 0, 0, 2, VAL_MIN, 1);
    add_dir(KIND_READ,   0,       1,  1, 0, 0, 0, 2, VAL_MAX, 1);
    add_dir(KIND_READ,   0,       2,  1, 0, 0, 0, 2, 0,       0);
    add_dir(KIND_READ,   0,       63, 1, 0, 0, 0, 2, 0,       0);
    add_dir(KIND_QUERY,  VAL_MIN, 0,  1, 1, 0, 0, 2, 0,       0);
    add_dir(KIND_QUERY,  VAL_MIN + 1, 0, 1, 0, 0, 0, 2, 0,    0);
    add_dir(KIND_INSERT, 0,       0,  1, 0, 1, 0, 3, 0,       0);
    add_dir(KIND_INSERT, -1,      0,  1, 0, 1, 0, 4, 0,       0);
    // Membership also reported on a read
    add_dir(KIND_READ,   -1,      1,  1, 1, 0, 0, 4, -1,      1);
    // Rank is ignored on a query
    add_dir(KIND_QUERY,  -1,      63, 1, 1, 0, 0, 4, 0,       0);
    add_dir(KIND_INSERT, 12345,   0,  0, 0, 0, 0, 0, 0,       0);
    add_dir(KIND_INSERT, -77,     0,  0, 0, 0, 0, 0, 0,       0);
    add_dir(KIND_INSERT, 1,       0,  0, 0, 0, 0, 0, 0,       0);
    add_dir(KIND_READ,   1,       3,  0, 0, 0, 0, 0, 0,       0);
    add_dir(KIND_READ,   0,       6,  0, 0, 0, 0, 0, 0,       0);
    add_dir(KIND_QUERY,  1,       0,  0, 0, 0, 0, 0, 0,       0);
    // Clear reports membership of its value before emptying the set
    add_dir(KIND_CLEAR,  0,       0,  1, 1, 0, 0, 0, 0,       0);
    add_dir(KIND_READ,   0,       0,  1, 0, 0, 0, 0, 0,       0);
    add_dir(KIND_CLEAR,  5,       0,  1, 0, 0, 0, 0, 0,       0);
    add_dir(KIND_INSERT, 5,       0,  1, 0, 1, 0, 1, 0,       0);

    // Hold reset, then release at a falling edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[n]) put_item(dir_rows[n].kind, dir_rows[n].value, dir_rows[n].rank);

    // Random episodes, each over a value pool of its own
    sent    = 0;
    episode = 0;
    while (sent < RANDOM_ITEMS) begin
      // Pause the sender until the block has drained
      if (episode == 2 || episode == 5) begin
        req_if.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      no_gap = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0: pool_size = 3;
        1: pool_size = 12;
        2: pool_size = 40;
        3: pool_size = 80;
        default: pool_size = 120;
      endcase
      pool.delete();
      for (i = 0; i < pool_size; i++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          case ($urandom_range(0, 4))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = 0;
            3: v = -1;
            default: v = 1;
          endcase
        end else if (pick < 5) begin
          v = int'($urandom_range(0, 200)) - 100;
        end else begin
          v = $urandom;
        end
        pool = {pool, v};
      end
      ep_len = (pool_size >= 80) ? 2 * pool_size : pool_size + $urandom_range(10, 60);
      // Start most episodes from an empty set
      if ($urandom_range(0, 9) < 7) begin
        put_item(KIND_CLEAR, pool[$urandom_range(0, pool_size - 1)],
                 RANK_W'($urandom_range(0, 63)));
        sent++;
      end
      for (i = 0; i < ep_len && sent < RANDOM_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)      k = KIND_INSERT;
        else if (pick < 75) k = KIND_QUERY;
        else if (pick < 97) k = KIND_READ;
        else                k = KIND_CLEAR;
        if ($urandom_range(0, 99) < 85) v = pool[$urandom_range(0, pool_size - 1)];
        else                            v = $urandom;
        rank_top = (set_count > 63) ? 63 : set_count;
        if (set_count > 0 && $urandom_range(0, 9) < 7) r = RANK_W'($urandom_range(0, rank_top));
        else                                           r = RANK_W'($urandom_range(0, 63));
        put_item(k, v, r);
        sent++;
      end
      episode++;
    end
    req_if.valid <= 1'b0;

    // Drain outstanding responses, then allow for the pipeline latency
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb_sorted_integer_set_top: clean");
    end else begin
      $display("tb_sorted_integer_set_top: errors");
    end
    $finish;
  end

endmodule
